FILE: src/tcge_pkg.sv
package tcge_pkg;

  // Default console geometry.
  localparam int unsigned TEXT_COLS_DEF   = 80;
  localparam int unsigned TEXT_ROWS_DEF   = 25;
  localparam int unsigned GLYPH_ROWS_DEF  = 16;
  localparam int unsigned TAB_STEP_DEF    = 8;
  localparam int unsigned GLYPH_COUNT_DEF = 256;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Command field layout inside the output tdata.
  localparam int X_W       = 10;
  localparam int Y_W       = 9;
  localparam int MASK_W    = 8;
  localparam int VALUE_W   = 24;
  localparam int X_LSB     = 0;
  localparam int Y_LSB     = X_LSB + X_W;
  localparam int MASK_LSB  = Y_LSB + Y_W;
  localparam int VALUE_LSB = MASK_LSB + MASK_W;
  localparam int OUT_PAD_W = OUT_DATA_W - (VALUE_LSB + VALUE_W);

  typedef enum logic [0:0] {
    KIND_LOAD  = 1'b0,
    KIND_PRINT = 1'b1
  } tcge_kind_e;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCROLL = 2'd2
  } tcge_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRAW_COLOR   = 1'b0,
    CFG_CURSOR_GLYPH = 1'b1
  } tcge_cfg_e;

  typedef enum logic [1:0] {
    COLOR_RED   = 2'd0,
    COLOR_BLUE  = 2'd1,
    COLOR_GREEN = 2'd2,
    COLOR_WHITE = 2'd3
  } tcge_color_e;

  // Control characters.
  localparam logic [7:0] CHAR_BS  = 8'd8;
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_NL  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  localparam logic [7:0] CURSOR_GLYPH_RST = 8'd178;

  function automatic logic [VALUE_W-1:0] color_value(logic [1:0] code);
    logic [VALUE_W-1:0] v;
    unique case (tcge_color_e'(code))
      COLOR_RED:   v = 24'h0000FF;
      COLOR_BLUE:  v = 24'hFF0000;
      COLOR_GREEN: v = 24'h00FF00;
      COLOR_WHITE: v = 24'hFFFFFF;
      default:     v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/tcge_font_store.sv
module tcge_font_store import tcge_pkg::*; #(
  parameter int unsigned DEPTH = GLYPH_COUNT_DEF * GLYPH_ROWS_DEF,
  parameter int          AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  // One write port and one registered read port.
  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/text_console_glyph_engine_core.sv
// Text console glyph engine. The block keeps a font store of GLYPH_COUNT glyphs of
// GLYPH_ROWS lines each and a cursor on a TEXT_COLS x TEXT_ROWS character grid, and
// turns each printed character into a stream of pixel mask commands for a framebuffer
// writer: the cursor glyph is erased, the character is handled (tab, return, newline,
// backspace or a printable glyph), and the cursor is drawn again unless a backspace at the
// left margin ends the character. A text-line scroll is a single command. A font load
// transfer writes one font row byte. A print transfer occupies the block for one to three
// glyph passes; each pass first primes the font read and then issues one command per glyph
// row, one command per cycle while the output side does not stall, and a scroll adds one
// command. The rate is set by the single read port of the font store, which delivers one
// glyph row per cycle, and by the one command register on the output side. The input side
// is not ready while a character is being worked on. Configuration writes are always
// accepted and should only be issued while the block is idle.
module text_console_glyph_engine_core import tcge_pkg::*; #(
  parameter int unsigned TEXT_COLS   = TEXT_COLS_DEF,
  parameter int unsigned TEXT_ROWS   = TEXT_ROWS_DEF,
  parameter int unsigned GLYPH_ROWS  = GLYPH_ROWS_DEF,
  parameter int unsigned TAB_STEP    = TAB_STEP_DEF,
  parameter int unsigned GLYPH_COUNT = GLYPH_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata fields from bit 0 up: font_index[11:0], font_byte[19:12], char_code[27:20].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser fields: kind[0].
  input  logic [0:0]            s_axis_tuser,
  // Command stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata fields from bit 0 up: pixel_x[9:0], pixel_y[18:10], row_mask[26:19],
  // pixel_value[50:27].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser fields: op[1:0].
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW = $clog2(FONT_DEPTH);
  localparam int CW = $clog2(TEXT_COLS);
  localparam int RW = $clog2(TEXT_ROWS);
  localparam int GW = $clog2(GLYPH_ROWS);
  // The tab sum must hold the last column plus the largest tab step.
  localparam int TW = CW + 5;

  localparam logic [CW-1:0] COL_LAST  = CW'(TEXT_COLS - 1);
  localparam logic [RW-1:0] ROW_LAST  = RW'(TEXT_ROWS - 1);
  localparam logic [GW-1:0] GROW_LAST = GW'(GLYPH_ROWS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRIME,
    S_PASS,
    S_SCROLL
  } state_e;

  typedef enum logic [1:0] {
    PH_ERASE,
    PH_BODY,
    PH_REDRAW
  } phase_e;

  typedef enum logic [2:0] {
    CLS_TAB,
    CLS_CR,
    CLS_NL,
    CLS_BS,
    CLS_PRT
  } cls_e;

  // Description of one glyph pass: what to do, which glyph, and whether its last
  // row closes the character.
  typedef struct packed {
    tcge_op_e   op;
    logic [7:0] code;
    logic       solid;
    logic       blank;
    logic       fin;
  } pass_t;

  function automatic pass_t mk_pass(tcge_op_e op, logic [7:0] code, logic solid,
                                    logic fin);
    pass_t p;
    p.op    = op;
    p.code  = code;
    p.solid = solid;
    p.blank = (9'(code) >= 9'(GLYPH_COUNT));
    p.fin   = fin;
    return p;
  endfunction

  // Input field unpacking.
  logic [11:0] in_font_index;
  logic [7:0]  in_font_byte;
  logic [7:0]  in_char;
  cls_e        in_cls;

  assign in_font_index = s_axis_tdata[11:0];
  assign in_font_byte  = s_axis_tdata[19:12];
  assign in_char       = s_axis_tdata[27:20];

  always_comb begin
    unique case (in_char)
      CHAR_TAB: in_cls = CLS_TAB;
      CHAR_CR:  in_cls = CLS_CR;
      CHAR_NL:  in_cls = CLS_NL;
      CHAR_BS:  in_cls = CLS_BS;
      default:  in_cls = CLS_PRT;
    endcase
  end

  // Configuration registers.
  logic [1:0] draw_color_q;
  logic [7:0] cursor_glyph_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q   <= '0;
      cursor_glyph_q <= CURSOR_GLYPH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tcge_cfg_e'(cfg_index_i))
        CFG_DRAW_COLOR:   draw_color_q   <= cfg_data_i[1:0];
        CFG_CURSOR_GLYPH: cursor_glyph_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  state_e        state_q;
  phase_e        phase_q;
  cls_e          cls_q;
  logic [7:0]    char_q;
  pass_t         pass_q;
  logic [GW-1:0] grow_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  // Output command register.
  logic               m_valid_q;
  tcge_op_e           m_op_q;
  logic [X_W-1:0]     m_x_q;
  logic [Y_W-1:0]     m_y_q;
  logic [MASK_W-1:0]  m_mask_q;
  logic [VALUE_W-1:0] m_value_q;
  logic               m_last_q;

  logic s_fire;
  logic out_free;
  logic pass_fire;
  logic font_we;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign pass_fire     = (state_q == S_PASS) && out_free;
  assign font_we       = s_fire && (tcge_kind_e'(s_axis_tuser) == KIND_LOAD) &&
                         (32'(in_font_index) < FONT_DEPTH);

  // The font read address runs one row ahead whenever a command leaves, so the
  // registered read data always belongs to the current glyph row during a pass.
  logic [GW-1:0] rd_grow;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    font_rd;

  assign rd_grow = pass_fire ? GW'(grow_q + 1'b1) : grow_q;
  assign rd_addr = AW'(32'(pass_q.code) * GLYPH_ROWS + 32'(rd_grow));
  assign wr_addr = AW'(in_font_index);

  tcge_font_store #(
    .DEPTH (FONT_DEPTH),
    .AW    (AW)
  ) u_font_store (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (wr_addr),
    .wdata_i (in_font_byte),
    .raddr_i (rd_addr),
    .rdata_o (font_rd)
  );

  // Command fields of the current glyph row.
  logic [X_W-1:0]     cmd_x;
  logic [Y_W-1:0]     cmd_y;
  logic [MASK_W-1:0]  cmd_mask;
  logic [VALUE_W-1:0] cmd_value;
  logic               cmd_last;

  assign cmd_x     = X_W'({col_q, 3'b000});
  assign cmd_y     = Y_W'(32'(row_q) * GLYPH_ROWS + 32'(grow_q));
  assign cmd_mask  = pass_q.solid ? 8'hFF : (pass_q.blank ? 8'h00 : font_rd);
  assign cmd_value = (pass_q.op == OP_SET) ? color_value(draw_color_q) : '0;
  assign cmd_last  = pass_q.fin && (grow_q == GROW_LAST);

  // Tab advance with saturation at the last column.
  logic [TW-1:0] tab_sum;
  logic [CW-1:0] tab_col;

  assign tab_sum = TW'(col_q) + TW'(TAB_STEP);
  assign tab_col = (tab_sum > TW'(TEXT_COLS - 1)) ? COL_LAST : CW'(tab_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= PH_ERASE;
      cls_q     <= CLS_PRT;
      char_q    <= '0;
      pass_q    <= '0;
      grow_q    <= '0;
      col_q     <= '0;
      row_q     <= '0;
      m_valid_q <= 1'b0;
      m_op_q    <= OP_SET;
      m_x_q     <= '0;
      m_y_q     <= '0;
      m_mask_q  <= '0;
      m_value_q <= '0;
      m_last_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_fire && (tcge_kind_e'(s_axis_tuser) == KIND_PRINT)) begin
            cls_q   <= in_cls;
            char_q  <= in_char;
            phase_q <= PH_ERASE;
            // A backspace at the left margin ends right after the erase.
            pass_q  <= mk_pass(OP_CLEAR, cursor_glyph_q, 1'b0,
                               (in_cls == CLS_BS) && (col_q == '0));
            grow_q  <= '0;
            state_q <= S_PRIME;
          end
        end

        S_PRIME: begin
          state_q <= S_PASS;
        end

        S_PASS: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_op_q    <= pass_q.op;
            m_x_q     <= cmd_x;
            m_y_q     <= cmd_y;
            m_mask_q  <= cmd_mask;
            m_value_q <= cmd_value;
            m_last_q  <= cmd_last;
            grow_q    <= GW'(grow_q + 1'b1);

            if (grow_q == GROW_LAST) begin
              // End of a pass: move the cursor and pick the next pass.
              grow_q  <= '0;
              state_q <= S_PRIME;
              unique case (phase_q)
                PH_ERASE: begin
                  phase_q <= PH_REDRAW;
                  pass_q  <= mk_pass(OP_SET, cursor_glyph_q, 1'b0, 1'b1);
                  case (cls_q)
                    CLS_TAB: col_q <= tab_col;
                    CLS_CR:  col_q <= '0;
                    CLS_NL: begin
                      if (row_q == ROW_LAST) begin
                        state_q <= S_SCROLL;
                      end else begin
                        row_q <= RW'(row_q + 1'b1);
                      end
                    end
                    CLS_BS: begin
                      if (col_q != '0) begin
                        col_q   <= CW'(col_q - 1'b1);
                        phase_q <= PH_BODY;
                        pass_q  <= mk_pass(OP_CLEAR, 8'h00, 1'b1, 1'b0);
                      end else begin
                        state_q <= S_IDLE;
                      end
                    end
                    default: begin
                      phase_q <= PH_BODY;
                      pass_q  <= mk_pass(OP_SET, char_q, 1'b0, 1'b0);
                    end
                  endcase
                end

                PH_BODY: begin
                  phase_q <= PH_REDRAW;
                  pass_q  <= mk_pass(OP_SET, cursor_glyph_q, 1'b0, 1'b1);
                  if (cls_q == CLS_PRT) begin
                    if (col_q == COL_LAST) begin
                      col_q <= '0;
                      if (row_q == ROW_LAST) begin
                        state_q <= S_SCROLL;
                      end else begin
                        row_q <= RW'(row_q + 1'b1);
                      end
                    end else begin
                      col_q <= CW'(col_q + 1'b1);
                    end
                  end
                end

                default: begin
                  state_q <= S_IDLE;
                end
              endcase
            end
          end
        end

        S_SCROLL: begin
          // The cursor redraw pass is already set up and follows the scroll.
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_op_q    <= OP_SCROLL;
            m_x_q     <= '0;
            m_y_q     <= '0;
            m_mask_q  <= '0;
            m_value_q <= '0;
            m_last_q  <= 1'b0;
            state_q   <= S_PRIME;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_op_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_value_q, m_mask_q, m_y_q, m_x_q};

endmodule

FILE: src/tcge_checker.sv
module tcge_checker import tcge_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [0:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A scroll command carries no coordinates and never closes a character.
  a_scroll_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == OP_SCROLL) |-> (m_axis_tdata == '0) && !m_axis_tlast)
    else $error("scroll command with nonzero fields or tlast");

  // A clear command writes no color.
  a_clear_no_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == OP_CLEAR) |->
      (m_axis_tdata[VALUE_LSB +: VALUE_W] == '0))
    else $error("clear command with nonzero pixel value");

  // Once a character is taken, the input side holds off at least for its erase pass.
  a_busy_after_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_PRINT) |=> !s_axis_tready)
    else $error("input ready right after a print transfer");

  // A stalled command holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("command changed while stalled");

endmodule

bind text_console_glyph_engine_core tcge_checker u_tcge_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
